// ===== rtl/ssrd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssrd_pkg
// Shared types and constants for the shadow slot race detector.
// ----------------------------------------------------------------------------
package ssrd_pkg;

    localparam int SLOTS       = 4;
    localparam int GRAIN       = 8;
    localparam int THREADS     = 16;
    localparam int GRANULES    = 1024;
    localparam int CLOCK_WIDTH = 16;

    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TID_W    = $clog2(THREADS);
    localparam int GRAN_W   = $clog2(GRANULES);
    localparam int OFF_W    = $clog2(GRAIN);
    localparam int BASE_W   = 29;
    localparam int ADDR_W   = 32;
    localparam int VC_W     = 2 * TID_W;
    localparam int SLOT_BITS = 1 + TID_W + CLOCK_WIDTH + OFF_W + 2 + 1;

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_CLKWR  = 1'b1;

    typedef struct packed {
        logic                   valid;
        logic [TID_W-1:0]       tid;
        logic [CLOCK_WIDTH-1:0] clock;
        logic [OFF_W-1:0]       offset;
        logic [1:0]             size;
        logic                   read;
    } slot_t;

    // Classified request handed from front to back.
    typedef struct packed {
        logic                   kind_clkwr;
        logic                   covered;
        logic [TID_W-1:0]       tid;
        logic [TID_W-1:0]       other;
        logic [CLOCK_WIDTH-1:0] value;
        logic [GRAN_W-1:0]      gran;
        logic [OFF_W-1:0]       offset;
        logic [1:0]             size;
        logic                   read;
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CLEAR, ST_READ, ST_CHECK, ST_EMIT
    } back_state_t;

endpackage

// ===== rtl/ssrd_front.sv =====
// ----------------------------------------------------------------------------
// ssrd_front
// Accept requests, classify against the window and queue them for the back.
// ----------------------------------------------------------------------------
module ssrd_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [28:0]            window_base,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_operation,
    input  logic [3:0]             s_thread_id,
    input  logic [31:0]            s_address,
    input  logic [1:0]             s_size_log2,
    input  logic                   s_is_read,
    input  logic [3:0]             s_other_thread,
    input  logic [15:0]            s_clock_value,
    output logic                   q_valid,
    input  logic                   q_ready,
    output ssrd_pkg::req_t         q_req
);
    import ssrd_pkg::*;

    localparam int DEPTH = 2;

    req_t             fifo_reg [DEPTH];
    logic             wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]       cnt_reg, cnt_next;
    req_t             req;
    logic [ADDR_W-OFF_W-1:0] gran_abs;
    logic [ADDR_W-OFF_W:0]   rel;

    always_comb begin
        gran_abs = s_address[ADDR_W-1:OFF_W];
        rel = {1'b0, gran_abs} - {{(ADDR_W-OFF_W+1-BASE_W){1'b0}}, window_base};
        req = '0;
        req.kind_clkwr = (s_operation == OP_CLKWR);
        req.tid     = s_thread_id[TID_W-1:0];
        req.other   = s_other_thread[TID_W-1:0];
        req.value   = s_clock_value[CLOCK_WIDTH-1:0];
        req.gran    = rel[GRAN_W-1:0];
        req.offset  = s_address[OFF_W-1:0];
        req.size    = s_size_log2;
        req.read    = s_is_read;
        req.covered = !req.kind_clkwr && !rel[ADDR_W-OFF_W]
                      && (rel[ADDR_W-OFF_W-1:0] < (ADDR_W-OFF_W)'(GRANULES));
    end

    assign s_ready = (cnt_reg != 2'(DEPTH));
    assign q_valid = (cnt_reg != 2'd0);
    assign q_req   = fifo_reg[rp_reg];

    always_comb begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (s_valid && s_ready) begin
            wp_next = ~wp_reg;
        end
        if (q_valid && q_ready) begin
            rp_next = ~rp_reg;
        end
        cnt_next = cnt_reg + 2'(s_valid && s_ready) - 2'(q_valid && q_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            fifo_reg[wp_reg] <= req;
        end
    end

endmodule

// ===== rtl/ssrd_back.sv =====
// ----------------------------------------------------------------------------
// ssrd_back
// Carry out queued requests: clock writes and shadow read-modify-write,
// then emit results, race reports one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module ssrd_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  ssrd_pkg::req_t       q_req,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_covered,
    output logic                 m_race,
    output logic                 m_stored,
    output logic [1:0]           m_slot_index,
    output logic [3:0]           m_old_thread,
    output logic [15:0]          m_old_clock,
    output logic [2:0]           m_old_offset,
    output logic [1:0]           m_old_size_log2,
    output logic                 m_old_is_read,
    output logic                 m_last
);
    import ssrd_pkg::*;

    // One shadow row holds all slots of a granule; one clock row holds a
    // thread's whole vector, so a single read yields its own clock and every
    // element the slot check needs.
    logic [SLOTS*SLOT_BITS-1:0]       shadow_mem [GRANULES];
    logic [THREADS*CLOCK_WIDTH-1:0]   vc_mem [THREADS];

    back_state_t state_reg, state_next;
    req_t        req_reg;
    logic [GRAN_W-1:0]              clr_reg, clr_next;
    logic [SLOTS*SLOT_BITS-1:0]     row_rd_reg;
    logic [CLOCK_WIDTH-1:0]         now_rd_reg;
    logic [THREADS*CLOCK_WIDTH-1:0] vrow_rd_reg;
    logic [SLOTS-1:0]           racy_reg, racy_next;
    slot_t                      seen_reg [SLOTS];
    logic                       stored_reg, stored_next;
    logic [SLOT_W-1:0]          idx_reg, idx_next;

    // output register
    logic        ov_reg, ov_next;
    logic        o_cov_reg, o_race_reg, o_st_reg, o_last_reg;
    logic [SLOT_W-1:0] o_idx_reg;
    slot_t       o_slot_reg;
    logic        o_load;
    logic        o_cov_n, o_race_n, o_st_n, o_last_n;
    logic [SLOT_W-1:0] o_idx_n;
    slot_t       o_slot_n;

    logic        rd_en, row_we, vc_we, vc_tick;
    logic [SLOTS*SLOT_BITS-1:0] row_new;

    slot_t  cur [SLOTS];
    slot_t  ent;
    logic   room;

    assign room = !ov_reg || m_ready;

    // Combinational slot check on the registered row.
    always_comb begin
        logic st;
        logic hb, same, ovl;
        logic [3:0] ae, be;
        st = 1'b0;
        ent.valid  = 1'b1;
        ent.tid    = req_reg.tid;
        ent.clock  = now_rd_reg;
        ent.offset = req_reg.offset;
        ent.size   = req_reg.size;
        ent.read   = req_reg.read;
        row_new    = row_rd_reg;
        racy_next  = '0;
        for (int i = 0; i < SLOTS; i++) begin
            cur[i] = slot_t'(row_rd_reg[i*SLOT_BITS +: SLOT_BITS]);
            hb   = vrow_rd_reg[cur[i].tid*CLOCK_WIDTH +: CLOCK_WIDTH] >= cur[i].clock;
            same = (cur[i].offset == ent.offset) && (cur[i].size == ent.size);
            ae   = {1'b0, cur[i].offset} + (4'd1 << cur[i].size);
            be   = {1'b0, ent.offset} + (4'd1 << ent.size);
            ovl  = !(ae <= {1'b0, ent.offset}) && !(be <= {1'b0, cur[i].offset});
            if (!cur[i].valid) begin
                if (!st) begin
                    row_new[i*SLOT_BITS +: SLOT_BITS] = ent;
                    st = 1'b1;
                end
            end else if (same) begin
                if (cur[i].tid != ent.tid) begin
                    if (hb) begin
                        row_new[i*SLOT_BITS +: SLOT_BITS] = ent;
                        st = 1'b1;
                    end else if (!(cur[i].read && ent.read)) begin
                        racy_next[i] = 1'b1;
                    end
                end
            end else if (ovl) begin
                if (!(cur[i].tid == ent.tid || (cur[i].read && ent.read) || hb)) begin
                    racy_next[i] = 1'b1;
                end
            end
        end
        if (!st) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (SLOT_W'(i) == SLOT_W'(now_rd_reg % SLOTS)) begin
                    row_new[i*SLOT_BITS +: SLOT_BITS] = ent;
                end
            end
        end
        stored_next = st;
    end

    always_comb begin
        logic [SLOTS-1:0] rest;
        logic found;
        state_next = state_reg;
        clr_next   = clr_reg;
        idx_next   = idx_reg;
        q_ready    = 1'b0;
        rd_en      = 1'b0;
        row_we     = 1'b0;
        vc_we      = 1'b0;
        vc_tick    = 1'b0;
        o_load     = 1'b0;
        o_cov_n    = 1'b0;
        o_race_n   = 1'b0;
        o_st_n     = 1'b0;
        o_last_n   = 1'b1;
        o_idx_n    = '0;
        o_slot_n   = '0;
        found      = 1'b0;
        rest       = '0;
        ov_next    = ov_reg && !m_ready;
        case (state_reg)
            ST_CLEAR: begin
                row_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == GRAN_W'(GRANULES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                q_ready = room;
            end
            ST_READ: begin
                // fetch row and clocks
                rd_en      = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                row_we     = 1'b1;
                vc_tick    = 1'b1;
                idx_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (room) begin
                    o_load  = 1'b1;
                    o_cov_n = 1'b1;
                    o_st_n  = stored_reg;
                    if (racy_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (!found && racy_reg[i] && SLOT_W'(i) >= idx_reg) begin
                                found    = 1'b1;
                                o_idx_n  = SLOT_W'(i);
                                o_slot_n = seen_reg[i];
                            end
                        end
                        for (int i = 0; i < SLOTS; i++) begin
                            rest[i] = racy_reg[i] && (SLOT_W'(i) > o_idx_n);
                        end
                        o_race_n = 1'b1;
                        o_last_n = (rest == '0);
                        idx_next = o_idx_n + 1'b1;
                        if (rest == '0) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (state_reg == ST_IDLE && q_valid && room) begin
            if (!q_req.covered) begin
                o_load = 1'b1;
                vc_we  = q_req.kind_clkwr;
            end else begin
                state_next = ST_READ;
            end
        end
        if (o_load) begin
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && q_valid && q_ready) begin
            req_reg <= q_req;
        end
        // the clock rows are swept in the first cycles of the clearing pass
        if (state_reg == ST_CLEAR && clr_reg < GRAN_W'(THREADS)) begin
            vc_mem[clr_reg[TID_W-1:0]] <= '0;
        end
        if (vc_we) begin
            vc_mem[q_req.tid][q_req.other*CLOCK_WIDTH +: CLOCK_WIDTH] <= q_req.value;
        end
        if (vc_tick) begin
            vc_mem[req_reg.tid][req_reg.tid*CLOCK_WIDTH +: CLOCK_WIDTH] <= now_rd_reg + 1'b1;
        end
        if (rd_en) begin
            row_rd_reg  <= shadow_mem[req_reg.gran];
            vrow_rd_reg <= vc_mem[req_reg.tid];
            now_rd_reg  <= vc_mem[req_reg.tid][req_reg.tid*CLOCK_WIDTH +: CLOCK_WIDTH];
        end
        if (row_we) begin
            if (state_reg == ST_CLEAR) begin
                shadow_mem[clr_reg] <= '0;
            end else begin
                shadow_mem[req_reg.gran] <= row_new;
            end
        end
        if (state_reg == ST_CHECK) begin
            racy_reg   <= racy_next;
            stored_reg <= stored_next;
            for (int i = 0; i < SLOTS; i++) begin
                seen_reg[i] <= cur[i];
            end
        end
        idx_reg <= idx_next;
        if (o_load) begin
            o_cov_reg  <= o_cov_n;
            o_race_reg <= o_race_n;
            o_st_reg   <= o_st_n;
            o_last_reg <= o_last_n;
            o_idx_reg  <= o_idx_n;
            o_slot_reg <= o_slot_n;
        end
    end

    assign m_valid         = ov_reg;
    assign m_covered       = o_cov_reg;
    assign m_race          = o_race_reg;
    assign m_stored        = o_st_reg;
    assign m_slot_index    = 2'(o_idx_reg);
    assign m_old_thread    = 4'(o_slot_reg.tid);
    assign m_old_clock     = 16'(o_slot_reg.clock);
    assign m_old_offset    = o_slot_reg.offset;
    assign m_old_size_log2 = o_slot_reg.size;
    assign m_old_is_read   = o_slot_reg.read;
    assign m_last          = o_last_reg;

endmodule

// ===== rtl/shadow_slot_race_detector_top.sv =====
// ----------------------------------------------------------------------------
// shadow_slot_race_detector_top
// Happens-before race detector over a window of shadow slots.
// ----------------------------------------------------------------------------
// A covered access reads its granule's shadow row and the thread's clocks,
// then checks and writes the row back, then emits its results, one per cycle
// while the receiver is ready; the next request is taken only once the last
// result is loaded. Clock writes and uncovered accesses give one result
// straight from idle. After reset a clearing pass sweeps the shadow memory
// and clock rows before requests are served; window_base writes are taken
// at any time.
module shadow_slot_race_detector_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [28:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [3:0]  s_thread_id,
    input  logic [31:0] s_address,
    input  logic [1:0]  s_size_log2,
    input  logic        s_is_read,
    input  logic [3:0]  s_other_thread,
    input  logic [15:0] s_clock_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_covered,
    output logic        m_race,
    output logic        m_stored,
    output logic [1:0]  m_slot_index,
    output logic [3:0]  m_old_thread,
    output logic [15:0] m_old_clock,
    output logic [2:0]  m_old_offset,
    output logic [1:0]  m_old_size_log2,
    output logic        m_old_is_read,
    output logic        m_last
);
    import ssrd_pkg::*;

    logic [28:0] base_reg;
    logic        q_valid, q_ready;
    req_t        q_req;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
        end else if (cfg_valid) begin
            base_reg <= cfg_data;
        end
    end

    ssrd_front u_front (
        .aclk, .aresetn, .window_base(base_reg),
        .s_valid, .s_ready, .s_operation, .s_thread_id, .s_address,
        .s_size_log2, .s_is_read, .s_other_thread, .s_clock_value,
        .q_valid, .q_ready, .q_req
    );

    ssrd_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_req,
        .m_valid, .m_ready, .m_covered, .m_race, .m_stored, .m_slot_index,
        .m_old_thread, .m_old_clock, .m_old_offset, .m_old_size_log2,
        .m_old_is_read, .m_last
    );

endmodule

// ===== rtl/ssrd_checker.sv =====
// ----------------------------------------------------------------------------
// ssrd_checker
// Port-level checks on the race detector's result channel.
// ----------------------------------------------------------------------------
module ssrd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_covered,
    input logic       m_race,
    input logic       m_stored,
    input logic [1:0] m_slot_index,
    input logic [3:0] m_old_thread,
    input logic       m_last
);
    a_race_cov: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_race |-> m_covered) else $error("race without cover");

    a_stored_cov: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stored |-> m_covered) else $error("stored without cover");

    a_plain_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_race |-> m_last && m_slot_index == 2'd0 && m_old_thread == 4'd0)
        else $error("plain result not clean");

    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_race && !m_last ##1 m_valid |->
        m_race && m_slot_index > $past(m_slot_index)) else $error("report order");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_slot_index))
        else $error("result dropped");

endmodule

bind shadow_slot_race_detector_top ssrd_checker u_ssrd_checker (
    .aclk, .aresetn, .m_valid, .m_ready, .m_covered, .m_race, .m_stored,
    .m_slot_index, .m_old_thread, .m_last
);

// ===== dv/shadow_slot_race_detector_top_tb.sv =====
// ----------------------------------------------------------------------------
// shadow_slot_race_detector_top_tb
// Self-checking bench: drives access checks and clock writes with random
// gaps and stalls, predicts race reports from a local shadow and clock model.
// ----------------------------------------------------------------------------
module shadow_slot_race_detector_top_tb;
    import ssrd_pkg::*;

    typedef struct packed {
        logic        op;
        logic [3:0]  tid;
        logic [31:0] addr;
        logic [1:0]  size;
        logic        rd;
        logic [3:0]  other;
        logic [15:0] value;
    } access_req_t;

    typedef struct packed {
        logic        covered;
        logic        race;
        logic        stored;
        logic [1:0]  slot;
        logic [3:0]  othread;
        logic [15:0] oclock;
        logic [2:0]  ooff;
        logic [1:0]  osize;
        logic        ord;
        logic        last;
    } race_report_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [28:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_operation = 1'b0;
    logic [3:0] s_thread_id = '0;
    logic [31:0] s_address = '0;
    logic [1:0] s_size_log2 = '0;
    logic s_is_read = 1'b0;
    logic [3:0] s_other_thread = '0;
    logic [15:0] s_clock_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_covered, m_race, m_stored, m_old_is_read, m_last;
    logic [1:0] m_slot_index, m_old_size_log2;
    logic [3:0] m_old_thread;
    logic [15:0] m_old_clock;
    logic [2:0] m_old_offset;

    shadow_slot_race_detector_top uut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // local copy of the detector state
    slot_t        shadow_row [GRANULES][SLOTS];
    logic [15:0]  vclock [THREADS][THREADS];
    logic [28:0]  window_base;

    access_req_t  pending_reqs[$];
    race_report_t expected_reports[$];
    int errors;
    int reports_seen;
    int races_seen;
    int hold_off;
    bit drive_done;
    bit s_taken = 1'b0;

    task automatic report_mismatch(input string what);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    function automatic bit ranges_overlap(input int ao, input int al, input int bo, input int bl);
        return !((ao + al <= bo) || (bo + bl <= ao));
    endfunction

    // work out the reports one request causes and update the local state
    task automatic predict_reports(input access_req_t r);
        race_report_t rep;
        slot_t        seen [SLOTS];
        bit           racy [SLOTS];
        slot_t        entry;
        logic [31:0]  gran;
        int           rel, n, i;
        bit           stored, hb;
        logic [15:0]  now;
        rep = '0;
        rep.last = 1'b1;
        if (r.op == OP_CLKWR) begin
            vclock[r.tid][r.other] = r.value;
            expected_reports.push_back(rep);
            return;
        end
        gran = r.addr >> 3;
        if (gran < window_base || gran - window_base >= GRANULES) begin
            expected_reports.push_back(rep);
            return;
        end
        rel = gran - window_base;
        now = vclock[r.tid][r.tid];
        vclock[r.tid][r.tid] = now + 16'd1;
        entry = '{valid: 1'b1, tid: r.tid, clock: now, offset: r.addr[2:0],
                  size: r.size, read: r.rd};
        stored = 0;
        for (i = 0; i < SLOTS; i++) begin
            seen[i] = shadow_row[rel][i];
            racy[i] = 0;
            if (!seen[i].valid) begin
                if (!stored) begin
                    shadow_row[rel][i] = entry;
                    stored = 1;
                end
            end else begin
                hb = vclock[r.tid][seen[i].tid] >= seen[i].clock;
                if (seen[i].offset == entry.offset && seen[i].size == entry.size) begin
                    if (seen[i].tid != entry.tid) begin
                        if (hb) begin
                            shadow_row[rel][i] = entry;
                            stored = 1;
                        end else if (!(seen[i].read && entry.read)) begin
                            racy[i] = 1;
                        end
                    end
                end else if (ranges_overlap(seen[i].offset, 1 << seen[i].size,
                                            entry.offset, 1 << entry.size)) begin
                    if (!(seen[i].tid == entry.tid || (seen[i].read && entry.read) || hb))
                        racy[i] = 1;
                end
            end
        end
        if (!stored)
            shadow_row[rel][now % SLOTS] = entry;
        n = 0;
        for (i = 0; i < SLOTS; i++) begin
            if (racy[i]) begin
                rep = '{covered: 1'b1, race: 1'b1, stored: stored, slot: i[1:0],
                        othread: seen[i].tid, oclock: seen[i].clock,
                        ooff: seen[i].offset, osize: seen[i].size,
                        ord: seen[i].read, last: 1'b0};
                expected_reports.push_back(rep);
                n++;
            end
        end
        if (n == 0) begin
            rep = '0;
            rep.covered = 1'b1;
            rep.stored = stored;
            rep.last = 1'b1;
            expected_reports.push_back(rep);
        end else begin
            expected_reports[$].last = 1'b1;
        end
    endtask

    // mark the rising edges at which the input request was taken
    always @(posedge aclk) begin
        s_taken <= aresetn && s_valid && s_ready;
    end

    // driver: one request at a time, random gap before each
    int gap;
    always @(negedge aclk) begin
        access_req_t r;
        if (aresetn) begin
            if (s_taken) begin
                // accepted at the last rising edge
                predict_reports(pending_reqs.pop_front());
                s_valid <= 1'b0;
                gap = $urandom_range(0, 10);
            end else if (!s_valid && pending_reqs.size() > 0) begin
                if (gap > 0) begin
                    gap--;
                end else begin
                    r = pending_reqs[0];
                    s_valid <= 1'b1;
                    s_operation <= r.op;
                    s_thread_id <= r.tid;
                    s_address <= r.addr;
                    s_size_log2 <= r.size;
                    s_is_read <= r.rd;
                    s_other_thread <= r.other;
                    s_clock_value <= r.value;
                end
            end
        end
    end

    // receiver stall: random per report, plus a long hold-off when asked
    int stall;
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off--;
            m_ready <= 1'b0;
        end else if (m_ready && m_valid) begin
            stall = $urandom_range(0, 10);
            m_ready <= (stall == 0);
        end else if (stall > 0) begin
            stall--;
            m_ready <= (stall == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        race_report_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_covered, m_race, m_stored, m_slot_index, m_old_thread, m_old_clock,
                    m_old_offset, m_old_size_log2, m_old_is_read, m_last};
            reports_seen++;
            if (m_race)
                races_seen++;
            if (expected_reports.size() == 0) begin
                report_mismatch("report with nothing expected");
            end else begin
                want = expected_reports.pop_front();
                if (got.covered !== want.covered) report_mismatch("covered");
                if (got.race !== want.race) report_mismatch("race");
                if (got.stored !== want.stored) report_mismatch("stored");
                if (got.slot !== want.slot) report_mismatch("slot_index");
                if (got.othread !== want.othread) report_mismatch("old_thread");
                if (got.oclock !== want.oclock) report_mismatch("old_clock");
                if (got.ooff !== want.ooff) report_mismatch("old_offset");
                if (got.osize !== want.osize) report_mismatch("old_size_log2");
                if (got.ord !== want.ord) report_mismatch("old_is_read");
                if (got.last !== want.last) report_mismatch("last");
            end
        end
    end

    function automatic access_req_t make_access(input logic [3:0] t, input logic [31:0] a,
                                                input logic [1:0] sz, input logic rd);
        access_req_t r;
        r = '0;
        r.op = OP_ACCESS;
        r.tid = t;
        r.addr = a;
        r.size = sz;
        r.rd = rd;
        r.other = $urandom;
        r.value = $urandom;
        return r;
    endfunction

    function automatic access_req_t make_clkwr(input logic [3:0] t, input logic [3:0] o,
                                               input logic [15:0] v);
        access_req_t r;
        r = '0;
        r.op = OP_CLKWR;
        r.tid = t;
        r.other = o;
        r.value = v;
        r.addr = $urandom;
        r.size = $urandom;
        r.rd = $urandom;
        return r;
    endfunction

    // wait for every report, then a latency margin before touching config
    task automatic drain();
        wait (pending_reqs.size() == 0 && !s_valid && expected_reports.size() == 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_base(input logic [28:0] b);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= b;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        window_base = b;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // random traffic inside a few hot granules so slots fill and race
    task automatic random_phase(input int count, input logic [28:0] base);
        access_req_t r;
        logic [31:0] a;
        int k;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(0, 9))
                0: r = make_clkwr($urandom, $urandom, $urandom);
                1: r = make_access($urandom, $urandom, $urandom, $urandom);
                default: begin
                    a = ({3'b0, base} + $urandom_range(0, 5)) << 3;
                    if ($urandom_range(0, 7) == 0)
                        a = ({3'b0, base} + GRANULES - 1 - $urandom_range(0, 1)) << 3;
                    a[2:0] = $urandom;
                    r = make_access($urandom_range(0, 3), a, $urandom, $urandom);
                end
            endcase
            pending_reqs.push_back(r);
        end
    endtask

    initial begin
        logic [31:0] g;
        int p;
        errors = 0;
        reports_seen = 0;
        races_seen = 0;
        hold_off = 0;
        stall = 0;
        gap = 0;
        window_base = '0;
        for (int i = 0; i < GRANULES; i++)
            for (int j = 0; j < SLOTS; j++)
                shadow_row[i][j] = '0;
        for (int i = 0; i < THREADS; i++)
            for (int j = 0; j < THREADS; j++)
                vclock[i][j] = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset base, ordered write/write and overlap, supersede, crossing, read/read
        write_base(29'd4);
        g = 32'd4 << 3;
        pending_reqs.push_back(make_access(4'd0, g, 2'd3, 1'b0));
        pending_reqs.push_back(make_access(4'd1, g, 2'd3, 1'b0));      // write/write, ordered: supersedes
        pending_reqs.push_back(make_access(4'd2, g + 4, 2'd2, 1'b1));  // overlap, ordered: no race
        pending_reqs.push_back(make_access(4'd3, g + 7, 2'd3, 1'b0));  // crosses granule
        pending_reqs.push_back(make_access(4'd0, g, 2'd3, 1'b0));      // same thread/range
        pending_reqs.push_back(make_clkwr(4'd15, 4'd0, 16'hFFFF));
        pending_reqs.push_back(make_access(4'd15, g, 2'd3, 1'b0));     // supersedes thread 0
        pending_reqs.push_back(make_access(4'd5, g + 8, 2'd0, 1'b1));
        pending_reqs.push_back(make_access(4'd6, g + 8, 2'd0, 1'b1));  // read/read, no race
        pending_reqs.push_back(make_access(4'd7, 32'd0, 2'd0, 1'b0));  // below window
        pending_reqs.push_back(make_access(4'd7, (32'd4 + GRANULES) << 3, 2'd1, 1'b0));
        pending_reqs.push_back(make_access(4'd8, (32'd3 + GRANULES) << 3 | 32'd7, 2'd3, 1'b1));
        pending_reqs.push_back(make_access(4'd9, 32'hFFFF_FFFF, 2'd3, 1'b1));
        pending_reqs.push_back(make_clkwr(4'd9, 4'd9, 16'hFFFF));
        pending_reqs.push_back(make_access(4'd9, g + 16, 2'd1, 1'b0));  // clock wraps
        pending_reqs.push_back(make_access(4'd9, g + 16, 2'd1, 1'b0));
        pending_reqs.push_back(make_clkwr(4'd0, 4'd15, 16'h0000));
        drain();

        write_base(29'h1FFF_FFFF);
        pending_reqs.push_back(make_access(4'd1, 32'hFFFF_FFF8, 2'd3, 1'b0));
        pending_reqs.push_back(make_access(4'd2, 32'hFFFF_FFFC, 2'd2, 1'b0));
        drain();

        write_base(29'd0);
        pending_reqs.push_back(make_access(4'd3, 32'd0, 2'd0, 1'b0));
        pending_reqs.push_back(make_access(4'd4, 32'd0, 2'd0, 1'b1));
        drain();

        // random phases at several bases; a long receiver hold-off in the first
        for (p = 0; p < 4; p++) begin
            case (p)
                0: write_base(29'd0);
                1: write_base(29'd100);
                2: write_base(29'h1FFF_FFFF - GRANULES);
                default: write_base($urandom_range(0, 29'h1FFF_0000));
            endcase
            random_phase(95, window_base);
            if (p == 0) begin
                @(negedge aclk);
                hold_off = 300;
            end
            drain();
        end
        drive_done = 1;
    end

    initial begin
        drive_done = 0;
        wait (drive_done);
        repeat (50) @(posedge aclk);
        $display("Ran %0d reports, %0d of them races, across several window settings",
                 reports_seen, races_seen);
        if (errors == 0 && expected_reports.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
